[src/arp_cache_and_responder_defines.svh]
// Assertion macros used by the RTL file arp_seq.sv.
`ifndef ARP_CACHE_AND_RESPONDER_DEFINES_SVH
`define ARP_CACHE_AND_RESPONDER_DEFINES_SVH

// Check on every clock edge outside reset.
`define ARP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Check on every clock edge, reset included.
`define ARP_ASSERT_ALL(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

[src/arp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package arp_pkg;

   localparam int ENTRIES_DEF = 16;

   localparam logic [1:0] KIND_ARP  = 2'd0;
   localparam logic [1:0] KIND_SEND = 2'd1;
   localparam logic [1:0] KIND_TICK = 2'd2;

   localparam logic [1:0] ACT_NONE  = 2'd0;
   localparam logic [1:0] ACT_REPLY = 2'd1;
   localparam logic [1:0] ACT_SEND  = 2'd2;
   localparam logic [1:0] ACT_DROP  = 2'd3;

   localparam logic [15:0] OP_REQUEST   = 16'd1;
   localparam logic [15:0] GUESS_PREFIX = 16'hC001;

   localparam logic [1:0] CSR_MY_IP  = 2'd0;
   localparam logic [1:0] CSR_MY_MAC = 2'd1;
   localparam logic [1:0] CSR_EXPIRY = 2'd2;

   localparam logic [31:0] EXPIRY_RESET = 32'd60;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] opcode;
      logic [31:0] sender_ip;
      logic [47:0] sender_mac;
      logic [31:0] target_ip;
   } arp_req_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [47:0] dest_mac;
      logic [31:0] dest_ip;
      logic        cache_hit;
   } arp_rsp_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] ip;
      logic [47:0] mac;
      logic [31:0] stamp;
   } arp_entry_type;

   typedef struct packed {
      logic        fill;
      logic        touch;
      logic [31:0] ip;
      logic [47:0] mac;
      logic [31:0] stamp;
   } arp_wr_type;

   typedef struct packed {
      logic        match;
      logic        older;
      logic        fresh;
      logic [31:0] age;
   } arp_cmp_type;

endpackage

`default_nettype wire

[src/arp_cmp.sv]
`timescale 1ns / 1ps
`default_nettype none

module arp_cmp (
   input  arp_pkg::arp_entry_type entry,
   input  logic [31:0]            key,
   input  logic [31:0]            now,
   input  logic [31:0]            expiry,
   input  logic [31:0]            best_age,
   input  logic                   is_first,
   output arp_pkg::arp_cmp_type   res
);

   logic [31:0] age;

   assign age       = now - entry.stamp;
   assign res.age   = age;
   assign res.match = entry.valid && (entry.ip == key);
   assign res.older = is_first || (age > best_age);
   assign res.fresh = age < expiry;

endmodule

`default_nettype wire

[src/arp_table.sv]
`timescale 1ns / 1ps
`default_nettype none

module arp_table #(
   parameter  int ENTRIES = arp_pkg::ENTRIES_DEF,
   localparam int IDX_W   = $clog2(ENTRIES)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [IDX_W-1:0]       rd_addr,
   output arp_pkg::arp_entry_type rd_entry,
   input  logic [IDX_W-1:0]       wr_addr,
   input  arp_pkg::arp_wr_type    wr_cmd
);

   logic [31:0]            ip_ram_ff    [ENTRIES];
   logic [47:0]            mac_ram_ff   [ENTRIES];
   logic [31:0]            stamp_ram_ff [ENTRIES];
   logic [ENTRIES-1:0]     valid_ff;
   logic [ENTRIES-1:0]     valid_in;
   arp_pkg::arp_entry_type rd_entry_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr_cmd.fill) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_cmd.fill) begin
         ip_ram_ff[wr_addr]  <= wr_cmd.ip;
         mac_ram_ff[wr_addr] <= wr_cmd.mac;
      end
      if (wr_cmd.fill || wr_cmd.touch) begin
         stamp_ram_ff[wr_addr] <= wr_cmd.stamp;
      end
      rd_entry_ff.valid <= valid_ff[rd_addr];
      rd_entry_ff.ip    <= ip_ram_ff[rd_addr];
      rd_entry_ff.mac   <= mac_ram_ff[rd_addr];
      rd_entry_ff.stamp <= stamp_ram_ff[rd_addr];
   end

   assign rd_entry = rd_entry_ff;

endmodule

`default_nettype wire

[src/arp_seq.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "arp_cache_and_responder_defines.svh"

module arp_seq #(
   parameter  int ENTRIES = arp_pkg::ENTRIES_DEF,
   localparam int IDX_W   = $clog2(ENTRIES),
   localparam int CNT_W   = $clog2(ENTRIES + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [31:0]          my_ip,
   input  logic [31:0]          expiry,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  arp_pkg::arp_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output arp_pkg::arp_rsp_type rsp_data
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_WRITE  = 4'b0100,
      ST_FINISH = 4'b1000
   } arp_state_type;

   arp_state_type        state_ff, state_in;
   arp_pkg::arp_req_type item_ff, item_in;
   logic [31:0]          now_ff, now_in;
   logic [CNT_W-1:0]     issue_cnt_ff, issue_cnt_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]     rd_idx_ff, rd_idx_in;
   logic                 found_ff, found_in;
   logic [IDX_W-1:0]     found_idx_ff, found_idx_in;
   logic [47:0]          hit_mac_ff, hit_mac_in;
   logic                 hit_fresh_ff, hit_fresh_in;
   logic                 free_ff, free_in;
   logic [IDX_W-1:0]     free_idx_ff, free_idx_in;
   logic [31:0]          best_age_ff, best_age_in;
   logic [IDX_W-1:0]     best_idx_ff, best_idx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   arp_pkg::arp_rsp_type rsp_data_ff, rsp_data_in;

   logic                   req_accept;
   logic                   issue_more;
   logic                   rsp_load;
   logic [31:0]            scan_key;
   logic [IDX_W-1:0]       wr_addr;
   arp_pkg::arp_wr_type    wr_cmd;
   arp_pkg::arp_entry_type rd_entry;
   arp_pkg::arp_cmp_type   cmp_res;
   arp_pkg::arp_rsp_type   result;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign issue_more = (issue_cnt_ff < CNT_W'(ENTRIES));
   assign rsp_load   = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);
   assign scan_key   = (item_ff.kind == arp_pkg::KIND_ARP) ? item_ff.sender_ip
                                                           : item_ff.target_ip;

   arp_table #(.ENTRIES(ENTRIES)) u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_addr  (issue_cnt_ff[IDX_W-1:0]),
      .rd_entry (rd_entry),
      .wr_addr  (wr_addr),
      .wr_cmd   (wr_cmd)
   );

   arp_cmp u_cmp (
      .entry    (rd_entry),
      .key      (scan_key),
      .now      (now_ff),
      .expiry   (expiry),
      .best_age (best_age_ff),
      .is_first (rd_idx_ff == '0),
      .res      (cmp_res)
   );

   always_comb begin
      wr_addr      = found_ff ? found_idx_ff : (free_ff ? free_idx_ff : best_idx_ff);
      wr_cmd.fill  = (state_ff == ST_WRITE) && !found_ff;
      wr_cmd.touch = (state_ff == ST_WRITE) && found_ff;
      wr_cmd.ip    = item_ff.sender_ip;
      wr_cmd.mac   = item_ff.sender_mac;
      wr_cmd.stamp = now_ff;
   end

   always_comb begin
      result = '0;
      case (item_ff.kind)
         arp_pkg::KIND_ARP: begin
            if (item_ff.opcode == arp_pkg::OP_REQUEST && item_ff.target_ip == my_ip) begin
               result.action   = arp_pkg::ACT_REPLY;
               result.dest_mac = item_ff.sender_mac;
               result.dest_ip  = item_ff.sender_ip;
            end
         end
         arp_pkg::KIND_SEND: begin
            if (item_ff.sender_ip != my_ip) begin
               result.action = arp_pkg::ACT_DROP;
            end else if (found_ff && hit_fresh_ff) begin
               result.action    = arp_pkg::ACT_SEND;
               result.dest_mac  = hit_mac_ff;
               result.cache_hit = 1'b1;
            end else begin
               result.action   = arp_pkg::ACT_SEND;
               result.dest_mac = {arp_pkg::GUESS_PREFIX, item_ff.target_ip};
            end
         end
         default: begin
            result = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      now_in       = now_ff;
      issue_cnt_in = issue_cnt_ff;
      rd_vld_in    = 1'b0;
      rd_idx_in    = issue_cnt_ff[IDX_W-1:0];
      found_in     = found_ff;
      found_idx_in = found_idx_ff;
      hit_mac_in   = hit_mac_ff;
      hit_fresh_in = hit_fresh_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      best_age_in  = best_age_ff;
      best_idx_in  = best_idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      // fold in the entry read last cycle
      if (rd_vld_ff) begin
         if (cmp_res.match && !found_ff) begin
            found_in     = 1'b1;
            found_idx_in = rd_idx_ff;
            hit_mac_in   = rd_entry.mac;
            hit_fresh_in = cmp_res.fresh;
         end
         if (!rd_entry.valid && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = rd_idx_ff;
         end
         if (cmp_res.older) begin
            best_age_in = cmp_res.age;
            best_idx_in = rd_idx_ff;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               item_in      = req_data;
               issue_cnt_in = '0;
               found_in     = 1'b0;
               free_in      = 1'b0;
               state_in     = ST_FINISH;
               case (req_data.kind)
                  arp_pkg::KIND_ARP: begin
                     state_in = ST_SCAN;
                  end
                  arp_pkg::KIND_SEND: begin
                     if (req_data.sender_ip == my_ip) begin
                        state_in = ST_SCAN;
                     end
                  end
                  arp_pkg::KIND_TICK: begin
                     now_in = now_ff + 32'd1;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (issue_more) begin
               rd_vld_in    = 1'b1;
               issue_cnt_in = issue_cnt_ff + CNT_W'(1);
            end else if (!rd_vld_ff) begin
               state_in = (item_ff.kind == arp_pkg::KIND_ARP) ? ST_WRITE : ST_FINISH;
            end
         end
         ST_WRITE: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = result;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         now_ff       <= '0;
         issue_cnt_ff <= '0;
         rd_vld_ff    <= 1'b0;
         found_ff     <= 1'b0;
         free_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         now_ff       <= now_in;
         issue_cnt_ff <= issue_cnt_in;
         rd_vld_ff    <= rd_vld_in;
         found_ff     <= found_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      rd_idx_ff    <= rd_idx_in;
      found_idx_ff <= found_idx_in;
      hit_mac_ff   <= hit_mac_in;
      hit_fresh_ff <= hit_fresh_in;
      free_idx_ff  <= free_idx_in;
      best_age_ff  <= best_age_in;
      best_idx_ff  <= best_idx_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ARP_ASSERT(a_accept_leaves_idle, req_accept |=> (state_ff != ST_IDLE), "accepted beat left block idle")
   `ARP_ASSERT(a_write_only_arp, (state_ff == ST_WRITE) |-> (item_ff.kind == arp_pkg::KIND_ARP), "table write for non-ARP beat")
   `ARP_ASSERT(a_rsp_from_finish, $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH), "response raised outside finish")
   `ARP_ASSERT(a_scan_bound, issue_cnt_ff <= CNT_W'(ENTRIES), "scan counter ran past table")
   `ARP_ASSERT_ALL(a_reset_clears_rsp, reset |=> !rsp_valid_ff, "response valid survived reset")

endmodule

`default_nettype wire

[src/arp_cache_and_responder.sv]
// ARP cache and responder. Each beat on req_ is one event: a received ARP
// packet (its sender is always cached; a request for my_ip yields a reply),
// an outgoing IP packet (dropped unless its source is my_ip, else its next
// hop is resolved from the cache or guessed as C001 followed by the IP), or
// a time tick. Exactly one rsp_ beat follows each request beat, in order.
// The cache holds ENTRIES slots in a store with one read and one write
// port, searched one slot per clock through one shared compare unit. An ARP
// packet goes through scan, write and finish, an outgoing one through scan
// and finish, a tick, unknown kind or dropped packet straight to finish; no
// beat is accepted until the block is idle again, and rsp_stall can hold it
// in finish. No clearing pass is needed after reset: occupancy bits clear at
// once. Registers on csr_ may be written only while no beat is in flight.
`timescale 1ns / 1ps
`default_nettype none

module arp_cache_and_responder #(
   parameter int ENTRIES = arp_pkg::ENTRIES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [47:0]          csr_wdata,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  arp_pkg::arp_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output arp_pkg::arp_rsp_type rsp_data
);

   logic [31:0] my_ip_ff, my_ip_in;
   logic [31:0] expiry_ff, expiry_in;

   always_comb begin
      my_ip_in  = my_ip_ff;
      expiry_in = expiry_ff;
      if (csr_we) begin
         unique case (csr_index)
            arp_pkg::CSR_MY_IP: begin
               my_ip_in = csr_wdata[31:0];
            end
            arp_pkg::CSR_MY_MAC: begin
               // source MAC only feeds frame building outside this block; drop
            end
            arp_pkg::CSR_EXPIRY: begin
               expiry_in = csr_wdata[31:0];
            end
            default: begin
               my_ip_in = my_ip_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         my_ip_ff  <= '0;
         expiry_ff <= arp_pkg::EXPIRY_RESET;
      end else begin
         my_ip_ff  <= my_ip_in;
         expiry_ff <= expiry_in;
      end
   end

   arp_seq #(.ENTRIES(ENTRIES)) u_seq (
      .clock     (clock),
      .reset     (reset),
      .my_ip     (my_ip_ff),
      .expiry    (expiry_ff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
